// ===== sv/indexed_shift_list_unit_defines.svh =====
// Assertion macros shared by the checker of the indexed shift list unit.
// Each macro samples on clk and is disabled while rst is high.
`ifndef INDEXED_SHIFT_LIST_UNIT_DEFINES_SVH
`define INDEXED_SHIFT_LIST_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ISL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ISL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/isl_pkg.sv =====
// Shared types and constants of the indexed shift list unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package isl_pkg;

  localparam int ACT_W  = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;
  localparam int CAP_W  = 5;
  // Cell index width; covers up to 256 cells.
  localparam int IDX_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ      = 3'd0,
    ACT_ADD_FRONT = 3'd1,
    ACT_ADD_END   = 3'd2,
    ACT_INSERT    = 3'd3,
    ACT_REMOVE    = 3'd4,
    ACT_CLEAR     = 3'd5
  } act_t;

  typedef enum logic {
    ST_TAKE,
    ST_FINISH
  } state_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] rd_idx;
  } cell_cmd_t;

  // Controller to datapath strobes.
  typedef struct packed {
    logic cap_rd;
    logic rd_ok;
    logic load;
    logic ok;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/isl_cell.sv =====
// One element cell of the shift row: holds one element, takes a neighbor's or the new
// value on insert or remove, and drives the shared read bus on a hit. Uses isl_pkg.
`default_nettype none

module isl_cell #(
  parameter int WIDTH = 32,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  isl_pkg::cell_cmd_t   cmd,
  input  logic [WIDTH-1:0]     value,
  input  logic [WIDTH-1:0]     left,
  input  logic [WIDTH-1:0]     right,
  output logic [WIDTH-1:0]     data,
  output logic [WIDTH-1:0]     tap
);
  import isl_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [WIDTH-1:0] data_next;

  always_comb begin
    priority if (cmd.ins && (MY_IDX > cmd.pos)) begin
      data_next = left;
    end else if (cmd.ins && (MY_IDX == cmd.pos)) begin
      data_next = value;
    end else if (cmd.rem && (MY_IDX >= cmd.pos)) begin
      data_next = right;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign tap = (cmd.rd_idx == MY_IDX) ? data : '0;

endmodule

`default_nettype wire

// ===== sv/isl_ctrl.sv =====
// Controller of the indexed shift list unit: decodes actions, keeps the
// element count and the capacity register, and runs the two-phase handshake. Uses isl_pkg.
`default_nettype none

module isl_ctrl #(
  parameter  int DEPTH = 16,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [isl_pkg::ACT_W-1:0]   action,
  input  logic [isl_pkg::POS_W-1:0]   position,
  input  logic                        cfg_we,
  input  logic [isl_pkg::CAP_W-1:0]   cfg_wdata,
  input  logic                        out_stall,
  output logic                        out_valid,
  output isl_pkg::cell_cmd_t          cmd,
  output isl_pkg::ctl_t               ctl,
  output logic [CW-1:0]               count
);
  import isl_pkg::*;

  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  state_t           state, state_next;
  logic [CW-1:0]    count_next;
  logic [CAP_W-1:0] capacity;
  logic             ok, ok_next;
  logic             out_valid_next;

  logic [LW-1:0] cnt_x, cap_x, lim, pos_x;
  logic          room, pos_lt, pos_le;

  assign cnt_x  = LW'(count);
  assign cap_x  = LW'(capacity);
  assign lim    = (cap_x > LW'(DEPTH)) ? LW'(DEPTH) : cap_x;
  assign pos_x  = LW'(position);
  assign room   = cnt_x < lim;
  assign pos_lt = pos_x < cnt_x;
  assign pos_le = pos_x <= cnt_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_TAKE;
      count     <= '0;
      capacity  <= CAP_RESET;
      ok        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ok        <= ok_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ok_next        = ok;
    out_valid_next = out_valid && out_stall;
    in_stall       = 1'b0;
    cmd            = '0;
    cmd.rd_idx     = IDX_W'(position);
    ctl            = '0;
    ctl.ok         = ok;
    unique case (state)
      ST_TAKE: begin
        if (in_valid) begin
          ctl.cap_rd = 1'b1;
          ok_next    = 1'b0;
          state_next = ST_FINISH;
          unique case (act_t'(action))
            ACT_READ: begin
              if (pos_lt) begin
                ok_next    = 1'b1;
                ctl.rd_ok  = 1'b1;
              end
            end
            ACT_ADD_FRONT: begin
              if (room) begin
                ok_next    = 1'b1;
                cmd.ins    = 1'b1;
                cmd.pos    = '0;
                count_next = count + CW'(1);
              end
            end
            ACT_ADD_END: begin
              if (room) begin
                ok_next    = 1'b1;
                cmd.ins    = 1'b1;
                cmd.pos    = IDX_W'(count);
                count_next = count + CW'(1);
              end
            end
            ACT_INSERT: begin
              if (room && pos_le) begin
                ok_next    = 1'b1;
                cmd.ins    = 1'b1;
                cmd.pos    = IDX_W'(position);
                count_next = count + CW'(1);
              end
            end
            ACT_REMOVE: begin
              if (pos_lt) begin
                ok_next    = 1'b1;
                cmd.rem    = 1'b1;
                cmd.pos    = IDX_W'(position);
                count_next = count - CW'(1);
              end
            end
            ACT_CLEAR: begin
              ok_next    = 1'b1;
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FINISH: begin
        // read the tail through the shared bus, then hand off the result
        in_stall   = 1'b1;
        cmd.rd_idx = IDX_W'(count - CW'(1));
        if (!out_valid || !out_stall) begin
          ctl.load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_TAKE;
        end
      end
      default: begin
        state_next = ST_TAKE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/indexed_shift_list_unit.sv =====
// Top level of the indexed shift list unit: controller, row of element
// cells and the result register. Uses isl_pkg, isl_ctrl and isl_cell.
`default_nettype none

// An ordered list of up to DEPTH elements of WIDTH bits, held in a row of
// cells. Each transfer in carries an action (read, add front, add end,
// insert, remove, clear) and gives exactly one transfer out with ok, the
// element read, the first and last elements and the count after the action.
// In the cycle an item is taken, the whole cell row shifts at once and
// the element at position is read over the shared read bus; in the next
// cycle the same bus reads the tail element. The input is stalled during
// that tail read, which lasts until the result register is free of an
// earlier result, so no new item is taken before the last one is handed
// off. The capacity register may be written only while the block is idle.
module indexed_shift_list_unit #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [isl_pkg::ACT_W-1:0]   action,
  input  logic [isl_pkg::POS_W-1:0]   position,
  input  logic [isl_pkg::DATA_W-1:0]  value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        ok,
  output logic [isl_pkg::DATA_W-1:0]  read_data,
  output logic [isl_pkg::DATA_W-1:0]  first_value,
  output logic [isl_pkg::DATA_W-1:0]  last_value,
  output logic                        empty_res,
  output logic [isl_pkg::OCC_W-1:0]   occupancy,
  input  logic                        cfg_we,
  input  logic [isl_pkg::CAP_W-1:0]   cfg_wdata
);
  import isl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cell_cmd_t        cmd;
  ctl_t             ctl;
  logic [CW-1:0]    count;
  logic [WIDTH-1:0] value_m;
  logic [WIDTH-1:0] cell_data [DEPTH];
  logic [WIDTH-1:0] cell_tap  [DEPTH];
  logic [WIDTH-1:0] rd_bus;
  logic [WIDTH-1:0] rd_q;
  logic             cnt_zero;

  assign value_m  = WIDTH'(value);
  assign cnt_zero = (count == '0);

  isl_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .position  (position),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .ctl       (ctl),
    .count     (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left_in, right_in;
    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    isl_cell #(
      .WIDTH (WIDTH),
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .value (value_m),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i]),
      .tap   (cell_tap[i])
    );
  end

  // at most one cell drives a nonzero tap
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_rd) begin
      rd_q <= ctl.rd_ok ? rd_bus : '0;
    end
    if (ctl.load) begin
      ok          <= ctl.ok;
      read_data   <= DATA_W'(rd_q);
      first_value <= cnt_zero ? '0 : DATA_W'(cell_data[0]);
      last_value  <= cnt_zero ? '0 : DATA_W'(rd_bus);
      empty_res   <= cnt_zero;
      occupancy   <= OCC_W'(count);
    end
  end

endmodule

`default_nettype wire

// ===== sv/isl_checker.sv =====
// Port-level checker of the indexed shift list unit, bound to the top level.
// Uses isl_pkg and the assertion macros of indexed_shift_list_unit_defines.svh.
`default_nettype none

`include "indexed_shift_list_unit_defines.svh"

module isl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        ok,
  input logic [isl_pkg::DATA_W-1:0]  read_data,
  input logic [isl_pkg::DATA_W-1:0]  first_value,
  input logic [isl_pkg::DATA_W-1:0]  last_value,
  input logic                        empty_res,
  input logic [isl_pkg::OCC_W-1:0]   occupancy
);

  // the tail read cycle always follows a transfer in
  `ISL_ASSERT_NEXT(a_take_then_stall, in_valid && !in_stall, in_stall, "no stall after transfer in")

  // a new result appears only out of the tail read cycle
  `ISL_ASSERT_NOW(a_result_origin, $rose(out_valid), $past(in_stall), "result without tail read")

  `ISL_ASSERT_NOW(a_empty_view, out_valid && empty_res, occupancy == '0 && first_value == '0 && last_value == '0, "empty result not zero")

  `ISL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ok) && $stable(read_data) && $stable(occupancy), "stalled result changed")

endmodule

bind indexed_shift_list_unit isl_checker u_isl_checker (.*);

`default_nettype wire

// ===== tb/indexed_shift_list_unit_tb.sv =====
// Self-checking testbench for indexed_shift_list_unit: list actions, capacity writes.
// A small tracker class mirrors the list and checks each result transfer in order.
// Depends on isl_pkg and the indexed_shift_list_unit RTL.
`timescale 1ns / 1ps

module indexed_shift_list_unit_tb;
  import isl_pkg::*;

  localparam int LIST_DEPTH = 16;
  // Action codes with no function; the block must answer them with ok=0.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] first_value;
    logic [DATA_W-1:0] last_value;
    logic              empty_res;
    logic [OCC_W-1:0]  occupancy;
  } list_view_t;

  class list_tracker;
    logic [DATA_W-1:0] cells [LIST_DEPTH];
    int                fill;
    logic [CAP_W-1:0]  capacity;
    list_view_t        list_views [$];
    int                errors;

    function new();
      fill = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function int pending();
      return list_views.size();
    endfunction

    function void put_at(int p, logic [DATA_W-1:0] v);
      for (int k = fill; k > p; k--) cells[k] = cells[k-1];
      cells[p] = v;
      fill++;
    endfunction

    // Apply one accepted action and queue the view of the list it leaves.
    function void apply_action(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val);
      list_view_t v;
      int         limit;
      bit         room;
      int         p;
      v = '0;
      p = int'(pos);
      limit = (int'(capacity) > LIST_DEPTH) ? LIST_DEPTH : int'(capacity);
      room = fill < limit;
      case (act)
        ACT_READ: if (p < fill) begin
          v.read_data = cells[p];
          v.ok = 1'b1;
        end
        ACT_ADD_FRONT: if (room) begin
          put_at(0, val);
          v.ok = 1'b1;
        end
        ACT_ADD_END: if (room) begin
          put_at(fill, val);
          v.ok = 1'b1;
        end
        ACT_INSERT: if (room && p <= fill) begin
          put_at(p, val);
          v.ok = 1'b1;
        end
        ACT_REMOVE: if (p < fill) begin
          for (int k = p; k + 1 < fill; k++) cells[k] = cells[k+1];
          fill--;
          v.ok = 1'b1;
        end
        ACT_CLEAR: begin
          fill = 0;
          v.ok = 1'b1;
        end
        default: ;
      endcase
      if (fill > 0) begin
        v.first_value = cells[0];
        v.last_value = cells[fill-1];
      end else begin
        v.empty_res = 1'b1;
      end
      v.occupancy = OCC_W'(fill);
      list_views.push_back(v);
    endfunction

    function void compare_field(string field, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(list_view_t got);
      list_view_t want;
      if (list_views.size() == 0) begin
        $error("result transfer with no action outstanding");
        errors++;
        return;
      end
      want = list_views.pop_front();
      compare_field("ok", DATA_W'(want.ok), DATA_W'(got.ok));
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("first_value", want.first_value, got.first_value);
      compare_field("last_value", want.last_value, got.last_value);
      compare_field("empty_res", DATA_W'(want.empty_res), DATA_W'(got.empty_res));
      compare_field("occupancy", DATA_W'(want.occupancy), DATA_W'(got.occupancy));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [ACT_W-1:0]  action;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              ok;
  logic [DATA_W-1:0] read_data;
  logic [DATA_W-1:0] first_value;
  logic [DATA_W-1:0] last_value;
  logic              empty_res;
  logic [OCC_W-1:0]  occupancy;
  logic              cfg_we;
  logic [CAP_W-1:0]  cfg_wdata;

  list_tracker tracker = new();
  bit          quiet = 1'b0;
  int          out_hold = 0;

  indexed_shift_list_unit #(.DEPTH(LIST_DEPTH), .WIDTH(DATA_W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .read_data(read_data), .first_value(first_value),
    .last_value(last_value), .empty_res(empty_res), .occupancy(occupancy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Check the result transfer seen at this edge, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_result('{ok, read_data, first_value, last_value, empty_res,
                             occupancy});
    end
    if (out_hold == 0 && !quiet && !rst) begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  out_hold = 0;
        [70:94]: out_hold = $urandom_range(1, 3);
        default: out_hold = $urandom_range(10, 40);
      endcase
    end
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hold the item until the block takes it; an idle gap may come first.
  task automatic send_item(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                           logic [DATA_W-1:0] val);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 8);
    else gap = $urandom_range(15, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    position <= pos;
    value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.apply_action(act, pos, val);
  endtask

  // Drain all results, then write capacity while the block is idle.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.capacity = cap;
  endtask

  // Grow favors adds and inserts so the list reaches full; otherwise favor removes.
  task automatic send_random_item(bit grow);
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    int                r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 15) act = ACT_READ;
      else if (r < 30) act = ACT_ADD_FRONT;
      else if (r < 45) act = ACT_ADD_END;
      else if (r < 70) act = ACT_INSERT;
      else if (r < 85) act = ACT_REMOVE;
      else if (r < 88) act = ACT_CLEAR;
      else if (r < 91) act = r[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
      else act = ACT_READ;
    end else begin
      if (r < 20) act = ACT_READ;
      else if (r < 27) act = ACT_ADD_FRONT;
      else if (r < 34) act = ACT_ADD_END;
      else if (r < 45) act = ACT_INSERT;
      else if (r < 85) act = ACT_REMOVE;
      else if (r < 88) act = ACT_CLEAR;
      else if (r < 92) act = r[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
      else act = ACT_READ;
    end
    r = $urandom_range(0, 9);
    if (r < 2) pos = POS_W'($urandom_range(0, 31));
    else if (r < 4) pos = POS_W'(tracker.fill);
    else pos = POS_W'($urandom_range(0, tracker.fill));
    r = $urandom_range(0, 9);
    if (r == 0) val = '0;
    else if (r == 1) val = ALL_ONES;
    else val = $urandom();
    send_item(act, pos, val);
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [9];
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ACT_READ;
    position <= '0;
    value <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list, both ends, boundary positions, spare codes, clear.
    send_item(ACT_READ, 5'd0, 32'h0);
    send_item(ACT_REMOVE, 5'd0, 32'h0);
    send_item(ACT_ADD_END, 5'd0, ALL_ONES);
    send_item(ACT_ADD_FRONT, 5'd31, 32'h0);
    send_item(ACT_INSERT, 5'd1, 32'hA5A5_A5A5);
    send_item(ACT_INSERT, 5'd3, 32'h5A5A_5A5A);
    send_item(ACT_INSERT, 5'd31, 32'h1);
    send_item(ACT_INSERT, 5'd5, 32'h1);
    send_item(ACT_READ, 5'd3, 32'h0);
    send_item(ACT_READ, 5'd4, 32'h0);
    send_item(ACT_READ, 5'd31, ALL_ONES);
    send_item(ACT_REMOVE, 5'd4, 32'h0);
    send_item(ACT_REMOVE, 5'd3, 32'h0);
    send_item(ACT_REMOVE, 5'd0, 32'h0);
    send_item(ACT_SPARE_LO, 5'd0, 32'h1234_5678);
    send_item(ACT_SPARE_HI, 5'd31, ALL_ONES);
    send_item(ACT_CLEAR, 5'd0, 32'h0);
    send_item(ACT_CLEAR, 5'd0, 32'h0);
    // Small capacity: full list rejects adds and inserts.
    write_capacity(5'd2);
    send_item(ACT_ADD_END, 5'd0, 32'h1);
    send_item(ACT_ADD_END, 5'd0, 32'h2);
    send_item(ACT_ADD_FRONT, 5'd0, 32'h3);
    send_item(ACT_INSERT, 5'd0, 32'h4);
    // Capacity below the count: elements stay, reads and removes still work.
    write_capacity(5'd1);
    send_item(ACT_ADD_END, 5'd0, 32'h5);
    send_item(ACT_READ, 5'd1, 32'h0);
    send_item(ACT_REMOVE, 5'd0, 32'h0);
    write_capacity(5'd0);
    send_item(ACT_INSERT, 5'd0, 32'h6);

    phase_caps = '{5'd31, 5'd16, 5'd0, 5'd1, 5'd2, CAP_W'($urandom_range(1, 16)),
                   5'd17, CAP_W'($urandom_range(0, 31)), 5'd16};
    foreach (phase_caps[i]) begin
      write_capacity(phase_caps[i]);
      for (int c = 0; c < 2; c++) begin
        quiet = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < 50; n++) send_random_item(c == 0 || $urandom_range(0, 2) == 0);
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== indexed_shift_list_unit.f =====
+incdir+sv
sv/isl_pkg.sv
sv/isl_cell.sv
sv/isl_ctrl.sv
sv/indexed_shift_list_unit.sv
sv/isl_checker.sv
tb/indexed_shift_list_unit_tb.sv
